/* rtl/log_palette_gradient_colormap_core_assert.svh */
// Assertion macros shared by the colormap RTL; sampled on clk, disabled while arst_n is low.
`ifndef LOG_PALETTE_GRADIENT_COLORMAP_CORE_ASSERT_SVH
`define LOG_PALETTE_GRADIENT_COLORMAP_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define LPGC_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");
`define LPGC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define LPGC_ASSERT(lbl, expr)
`define LPGC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/lpgc_pkg.sv */
// Package: types, constants, log table and channel blend for the colormap.
`timescale 1ns / 1ps
`default_nettype none
package lpgc_pkg;
	localparam int unsigned PALETTE_ENTRIES_DEF = 16;
	localparam logic [15:0] MAX_ITER_RST = 16'd256;
	localparam int unsigned DIV_STEPS = 16;
	localparam logic [15:0] LOG_MAX = 16'd45426;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_COLOR = 1'b1;

	typedef struct packed {
		logic        op;
		logic [3:0]  idx;
		logic [23:0] col;
	} item_tag_t;

	// round(ln(1 + k/16) * 65536)
	function automatic logic [15:0] log_rom(input logic [4:0] k);
		logic [15:0] v;
		begin
			case (k)
				5'd0:  v = 16'd0;
				5'd1:  v = 16'd3973;
				5'd2:  v = 16'd7719;
				5'd3:  v = 16'd11262;
				5'd4:  v = 16'd14624;
				5'd5:  v = 16'd17821;
				5'd6:  v = 16'd20870;
				5'd7:  v = 16'd23783;
				5'd8:  v = 16'd26573;
				5'd9:  v = 16'd29248;
				5'd10: v = 16'd31818;
				5'd11: v = 16'd34292;
				5'd12: v = 16'd36675;
				5'd13: v = 16'd38975;
				5'd14: v = 16'd41196;
				5'd15: v = 16'd43347;
				5'd16: v = LOG_MAX;
				default: v = LOG_MAX;
			endcase
			return v;
		end
	endfunction

	// (a * (256 - f) + b * f) >> 8, truncating
	function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] f);
		logic [8:0]  inv;
		logic [16:0] sum;
		begin
			inv = 9'd256 - {1'b0, f};
			sum = 17'({8'b0, a} * inv) + 17'({9'b0, b} * {1'b0, f});
			return sum[15:8];
		end
	endfunction
endpackage
`default_nettype wire

/* rtl/log_palette_gradient_colormap_core.sv */
// Colormap core: maps an iteration count to an RGB colour through a log curve and a palette.
//
// Input stream s_axis: tuser[0] is the opcode. A load item (opcode 0) writes
// entry_color into palette entry entry_index and gives no result; a colour item
// (opcode 1) gives one 24-bit colour on m_axis. Items are handled in order, so a
// colour item sees every load accepted before it.
// Configuration: cfg_wr_en writes max_iterations from cfg_wr_data; write only
// while no item is in flight.
// Throughput: one item per cycle while the output is not stalled. The pipeline
// has 17 divider stages (one quotient bit each), 3 stages for the log table,
// interpolation and palette scaling, one palette read stage and the blend into
// the output register.
// Reset: palette reads as zero until an entry is written, max_iterations is 256,
// and the pipeline is empty.
// Stall: when the output register holds an item not taken, the whole pipeline
// holds and s_axis_tready falls; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "log_palette_gradient_colormap_core_assert.svh"
module log_palette_gradient_colormap_core
	import lpgc_pkg::*;
#(
	parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,   // max_iterations
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [3:0] entry_index, [27:4] entry_color, [43:28] iteration, [47:44] zero
	input  wire logic [47:0] s_axis_tdata,
	input  wire logic [0:0]  s_axis_tuser,  // [0] opcode
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata   // [23:0] pixel_color
);
	localparam int unsigned IW = $clog2(PALETTE_ENTRIES);
	localparam logic [IW-1:0] LAST_IDX = IW'(PALETTE_ENTRIES - 1);
	localparam int unsigned SW = 16 + IW;

	logic        ce;
	logic [15:0] max_iter_q;
	logic [15:0] lim;

	item_tag_t   in_tag;
	logic        div_vld;
	item_tag_t   div_tag;
	logic [16:0] div_t;

	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	item_tag_t   tag_s1, tag_s2, tag_s3;
	logic [15:0] base_s1;
	logic [23:0] prod_s1;
	logic [15:0] logv_s2;
	logic [SW-1:0] scaled_s3;
	logic [7:0]  frac_s4;
	logic        ent_a_s4, ent_b_s4;
	logic [23:0] pix_s5;

	logic [PALETTE_ENTRIES-1:0] ent_vld_q;

	logic [4:0]    k;
	logic [11:0]   diff;
	logic [IW-1:0] rd_idx_a, rd_idx_b;
	logic          wr_en;
	logic [IW-1:0] wr_idx;
	logic [23:0]   rdata_a, rdata_b, col_a, col_b;

	assign ce            = !vld_s5 || m_axis_tready;
	assign s_axis_tready = ce;
	assign m_axis_tvalid = vld_s5;
	assign m_axis_tdata  = pix_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= MAX_ITER_RST;
		end else if (cfg_wr_en) begin
			max_iter_q <= cfg_wr_data;
		end
	end

	// a zero limit acts as one
	assign lim = (max_iter_q == 16'd0) ? 16'd1 : max_iter_q;

	// op, idx, col from the top bit down
	assign in_tag = {s_axis_tuser[0], s_axis_tdata[3:0], s_axis_tdata[27:4]};

	lpgc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ce      (ce),
		.in_vld  (s_axis_tvalid),
		.in_tag  (in_tag),
		.in_it   (s_axis_tdata[43:28]),
		.lim     (lim),
		.out_vld (div_vld),
		.out_tag (div_tag),
		.out_t   (div_t)
	);

	// log table lookup and slope product
	assign k    = div_t[16:12];
	assign diff = 12'(log_rom(k + 5'd1) - log_rom(k));

	// palette indexes, next one wraps
	assign rd_idx_a = scaled_s3[16 +: IW];
	assign rd_idx_b = (rd_idx_a == LAST_IDX) ? '0 : rd_idx_a + 1'b1;

	// loads write at the read stage so the order of items holds
	assign wr_en  = ce && vld_s3 && (tag_s3.op == OP_LOAD)
		&& (9'(tag_s3.idx) < 9'(PALETTE_ENTRIES));
	assign wr_idx = IW'(tag_s3.idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			ent_vld_q <= '0;
		end else begin
			if (ce) begin
				vld_s1 <= div_vld;
				vld_s2 <= vld_s1;
				vld_s3 <= vld_s2;
				vld_s4 <= vld_s3 && (tag_s3.op == OP_COLOR);
				vld_s5 <= vld_s4;
			end
			if (wr_en) begin
				ent_vld_q[wr_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			tag_s1 <= div_tag;
			if (k[4]) begin
				base_s1 <= LOG_MAX;
				prod_s1 <= '0;
			end else begin
				base_s1 <= log_rom(k);
				prod_s1 <= diff * div_t[11:0];
			end
			tag_s2    <= tag_s1;
			logv_s2   <= base_s1 + 16'(prod_s1[23:12]);
			tag_s3    <= tag_s2;
			scaled_s3 <= logv_s2 * LAST_IDX;
			frac_s4   <= scaled_s3[15:8];
			ent_a_s4  <= ent_vld_q[rd_idx_a];
			ent_b_s4  <= ent_vld_q[rd_idx_b];
			pix_s5    <= {blend(col_a[23:16], col_b[23:16], frac_s4),
				blend(col_a[15:8], col_b[15:8], frac_s4),
				blend(col_a[7:0], col_b[7:0], frac_s4)};
		end
	end

	lpgc_ram #(
		.WIDTH (24),
		.DEPTH (PALETTE_ENTRIES)
	) u_palette (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (wr_idx),
		.wdata   (tag_s3.col),
		.re      (ce),
		.raddr_a (rd_idx_a),
		.raddr_b (rd_idx_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// entries never written read as zero
	assign col_a = ent_a_s4 ? rdata_a : 24'd0;
	assign col_b = ent_b_s4 ? rdata_b : 24'd0;

	`LPGC_ASSERT(a_log_range, !vld_s2 || (logv_s2 <= LOG_MAX))
	`LPGC_ASSERT(a_idx_range, !vld_s3 || (32'(rd_idx_a) < PALETTE_ENTRIES))
	`LPGC_ASSERT_NEXT(a_load_no_result, ce && vld_s3 && (tag_s3.op == OP_LOAD), !vld_s4)
endmodule
`default_nettype wire

/* rtl/lpgc_ram.sv */
// Generic RAM: one write port, two read ports with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lpgc_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end
endmodule
`default_nettype wire

/* rtl/lpgc_div.sv */
// Pipelined restoring divider: t = (count << 16) / limit, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
`include "log_palette_gradient_colormap_core_assert.svh"
module lpgc_div
	import lpgc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      ce,
	input  wire logic      in_vld,
	input  wire item_tag_t in_tag,
	input  wire logic [15:0] in_it,
	input  wire logic [15:0] lim,
	output logic           out_vld,
	output item_tag_t      out_tag,
	output logic [16:0]    out_t
);
	logic               vld_s [DIV_STEPS+1];
	item_tag_t          tag_s [DIV_STEPS+1];
	logic [15:0]        rem_s [DIV_STEPS+1];
	logic [16:0]        quo_s [DIV_STEPS+1];

	logic [15:0] it_sat;
	logic        top_bit;

	// saturate, then take the integer bit: count <= limit so it is 0 or 1
	assign it_sat  = (in_it > lim) ? lim : in_it;
	assign top_bit = (it_sat == lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (ce) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			tag_s[0] <= in_tag;
			rem_s[0] <= top_bit ? 16'd0 : it_sat;
			quo_s[0] <= {16'd0, top_bit};
		end
	end

	for (genvar g = 1; g <= DIV_STEPS; g++) begin : g_step
		logic [16:0] r2;
		logic [16:0] diff;
		logic        ge;

		assign r2   = {rem_s[g-1], 1'b0};
		assign diff = r2 - {1'b0, lim};
		assign ge   = (r2 >= {1'b0, lim});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (ce) begin
				vld_s[g] <= vld_s[g-1];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				tag_s[g] <= tag_s[g-1];
				rem_s[g] <= ge ? diff[15:0] : r2[15:0];
				quo_s[g] <= {quo_s[g-1][15:0], ge};
			end
		end
	end

	assign out_vld = vld_s[DIV_STEPS];
	assign out_tag = tag_s[DIV_STEPS];
	assign out_t   = quo_s[DIV_STEPS];

	`LPGC_ASSERT(a_rem_below_lim, !vld_s[DIV_STEPS] || (rem_s[DIV_STEPS] < lim))
	`LPGC_ASSERT(a_quo_range, !vld_s[DIV_STEPS] || (quo_s[DIV_STEPS] <= 17'h10000))
endmodule
`default_nettype wire

/* sim/tb.sv */
// Testbench for the log palette colormap core: self-checking against a predicted colour stream.
`timescale 1ns / 1ps
module tb;
	import lpgc_pkg::*;

	localparam int NPAL = 16;
	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;

	logic [23:0] palette_copy [NPAL];
	logic [15:0] limit_copy;
	logic [23:0] colour_queue [$];
	int          mismatches = 0;
	int          colours_seen = 0;
	int          loads_sent = 0;
	int          idle_cycles = 0;
	bit          hold_off = 1'b0;
	bit          quiet_sink = 1'b0;

	always #5 clk = ~clk;

	log_palette_gradient_colormap_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	function automatic logic [31:0] log_point(input int k);
		logic [31:0] t [17] = '{0, 3973, 7719, 11262, 14624, 17821, 20870, 23783,
			26573, 29248, 31818, 34292, 36675, 38975, 41196, 43347, 45426};
		return t[k];
	endfunction

	function automatic logic [7:0] mix_channel(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] f);
		logic [31:0] s;
		s = (a * (32'd256 - f) + b * f) >> 8;
		return s[7:0];
	endfunction

	function automatic logic [23:0] predict_colour(input logic [15:0] count);
		logic [31:0] lim, it, t, k, r, lg, sc, i1, i2, f;
		logic [23:0] c1, c2;
		lim = {16'b0, limit_copy};
		if (lim == 0) lim = 1;
		it = {16'b0, count};
		if (it > lim) it = lim;
		t = (it << 16) / lim;
		k = t >> 12;
		r = t & 32'd4095;
		if (k >= 16) lg = log_point(16);
		else lg = log_point(k) + (((log_point(k + 1) - log_point(k)) * r) >> 12);
		sc = lg * (NPAL - 1);
		i1 = (sc >> 16) % NPAL;
		i2 = (i1 + 1) % NPAL;
		f = (sc >> 8) & 32'd255;
		c1 = palette_copy[i1];
		c2 = palette_copy[i2];
		return {mix_channel(c1[23:16], c2[23:16], f), mix_channel(c1[15:8], c2[15:8], f),
			mix_channel(c1[7:0], c2[7:0], f)};
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	function automatic int gap_len();
		if ($urandom_range(0, 9) < 6) return 0;
		if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Send one item; the predictor runs at acceptance. Valid stays up for a
	// back-to-back item and drops only for a gap.
	task automatic send_item(input logic op, input logic [3:0] idx, input logic [23:0] col,
			input logic [15:0] count);
		int g;
		g = quiet_sink ? 0 : gap_len();
		if (g != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {4'b0, count, col, idx};
		do @(posedge clk); while (!s_axis_tready);
		if (op == OP_LOAD) begin
			palette_copy[idx] = col;
			loads_sent++;
		end else begin
			colour_queue.push_back(predict_colour(count));
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (colour_queue.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] v);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		limit_copy = v;
		@(posedge clk);
	endtask

	// Sink: random back-pressure, plus one long hold-off on request.
	always @(posedge clk) begin
		if (hold_off) m_axis_tready <= 1'b0;
		else if (quiet_sink) m_axis_tready <= 1'b1;
		else m_axis_tready <= ($urandom_range(0, 9) < 7);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			colours_seen++;
			if (colour_queue.size() == 0) report_mismatch("colour with nothing expected");
			else begin
				if (m_axis_tdata !== colour_queue[0])
					report_mismatch($sformatf("pixel_color got %h want %h",
						m_axis_tdata, colour_queue[0]));
				void'(colour_queue.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL log_palette_gradient_colormap_core");
			$finish;
		end
	end

	task automatic test_reset_palette();
		send_item(OP_COLOR, 4'hF, 24'hFFFFFF, 16'd0);
		send_item(OP_COLOR, 4'h0, 24'h000000, 16'd300);
	endtask

	task automatic test_directed();
		int i;
		for (i = 0; i < NPAL; i++)
			send_item(OP_LOAD, i[3:0], {i[7:0] * 8'd17, 8'hFF - i[7:0] * 8'd16, i[7:0]},
				16'hFFFF);
		send_item(OP_LOAD, 4'd15, 24'hFFFFFF, 16'd0);
		send_item(OP_COLOR, 4'd0, 24'd0, 16'd0);
		send_item(OP_COLOR, 4'd3, 24'hABCDEF, 16'd128);
		send_item(OP_COLOR, 4'd0, 24'd0, 16'd255);
		send_item(OP_COLOR, 4'd0, 24'd0, 16'd256);
		send_item(OP_COLOR, 4'd0, 24'd0, 16'hFFFF);
	endtask

	task automatic test_limits();
		write_limit(16'd0);
		send_item(OP_COLOR, 4'd0, 24'd0, 16'd0);
		send_item(OP_COLOR, 4'd0, 24'd0, 16'd5);
		write_limit(16'd1);
		send_item(OP_COLOR, 4'd0, 24'd0, 16'd1);
		write_limit(16'hFFFF);
		send_item(OP_COLOR, 4'd0, 24'd0, 16'h7FFF);
		send_item(OP_COLOR, 4'd0, 24'd0, 16'hFFFF);
	endtask

	task automatic random_phase(input int n);
		int i;
		logic [15:0] hi;
		hi = (limit_copy == 0) ? 16'd2 : limit_copy;
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 4) == 0)
				send_item(OP_LOAD, 4'($urandom()), 24'($urandom()), 16'($urandom()));
			else if ($urandom_range(0, 3) == 0)
				send_item(OP_COLOR, 4'($urandom()), 24'($urandom()), 16'($urandom()));
			else
				send_item(OP_COLOR, 4'($urandom()), 24'($urandom()),
					16'($urandom_range(0, 32'(hi) + 2)));
		end
	endtask

	task automatic test_random();
		random_phase(120);
		write_limit(16'($urandom_range(2, 1000)));
		random_phase(120);
		write_limit(16'd16);
		random_phase(120);
		write_limit(16'($urandom()));
		random_phase(100);
	endtask

	// Hold the sink off while the source keeps offering items.
	task automatic test_backpressure();
		int i;
		drain();
		quiet_sink = 1'b1;
		hold_off = 1'b1;
		fork
			begin
				repeat (80) @(posedge clk);
				hold_off = 1'b0;
			end
			for (i = 0; i < 40; i++) send_item(OP_COLOR, 4'd0, 24'd0, 16'($urandom()));
		join
		quiet_sink = 1'b0;
	endtask

	initial begin
		int k;
		for (k = 0; k < NPAL; k++) palette_copy[k] = '0;
		limit_copy = MAX_ITER_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_palette();
		test_directed();
		test_backpressure();
		test_limits();
		write_limit(16'd256);
		test_random();
		drain();
		$display("Covered %0d colours and %0d palette loads over several limits,", colours_seen,
			loads_sent);
		$display("including zero, one and full-scale limits and a long output stall.");
		if (mismatches == 0 && colour_queue.size() == 0)
			$display("PASS log_palette_gradient_colormap_core");
		else
			$display("FAIL log_palette_gradient_colormap_core");
		$finish;
	end
endmodule

/* log_palette_gradient_colormap_core.f */
+incdir+rtl
rtl/lpgc_pkg.sv
rtl/lpgc_ram.sv
rtl/lpgc_div.sv
rtl/log_palette_gradient_colormap_core.sv
sim/tb.sv
